// ----- src/ifg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifg_pkg
// Shared types and constants of the forward-difference gradient block.
// ----------------------------------------------------------------------------
package ifg_pkg;

    // configuration register widths and reset values
    localparam int FW_BITS  = 13;
    localparam int FH_BITS  = 16;
    localparam int ROW_BITS = 16;

    localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RESET = 16'd480;

    // configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 4'd1;

    // position flags of an accepted pixel, handed to the result sequencer
    typedef struct packed {
        logic has_above;   // a row above exists, its result is complete
        logic last_col;
        logic last_row;
        logic col_nz;      // left neighbour exists
    } ifg_ctrl_t;

endpackage

// ----- src/image_forward_gradient.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_forward_gradient
// Forward-difference gradient of a raster pixel stream, one line store.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  pixel     in         pixel_valid/stall      pixel
//  grad      out        grad_valid/stall       row, col, grad_x, grad_y, run_last
//  cfg       in         cfg_valid/ready        cfg_index, cfg_data
//
//  One pixel per cycle on all rows but the last while grad_stall is low; a
//  last-row pixel stalls input until its last result issues: one for the row
//  above if there is one, one for its left neighbour if there is one, and one
//  more on its last column; the single output register issues one per cycle.
//  An accepted pixel is held in the sequencer registers, and its first result
//  is then registered in the output register once that register is free.
//  Reset clears counters and the valid and pending state; the line store has no clearing pass.
//  grad_stall holds the output register and, once the sequencer is full,
//  raises pixel_stall in the same cycle.
// ----------------------------------------------------------------------------
module image_forward_gradient #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic signed [PIXEL_BITS-1:0]        pixel,
    output logic                                grad_valid,
    input  logic                                grad_stall,
    output logic [ifg_pkg::ROW_BITS-1:0]        row,
    output logic [$clog2(MAX_WIDTH)-1:0]        col,
    output logic signed [PIXEL_BITS:0]          grad_x,
    output logic signed [PIXEL_BITS:0]          grad_y,
    output logic                                run_last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ifg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ifg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import ifg_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int WB       = (FW_BITS > COL_BITS + 1) ? FW_BITS : COL_BITS + 1;

    logic [FW_BITS-1:0]           frame_width_reg;
    logic [FH_BITS-1:0]           frame_height_reg;
    logic [COL_BITS-1:0]          col_reg, col_next;
    logic [ROW_BITS-1:0]          row_reg, row_next;
    logic signed [PIXEL_BITS-1:0] prev_reg;

    logic [WB-1:0]                fw_ext, w_eff;
    logic [FH_BITS-1:0]           h_eff;
    logic                         last_col, last_row;
    logic                         accept, emit_free;
    logic [COL_BITS-1:0]          addr_right;
    logic [PIXEL_BITS-1:0]        above_raw, right_raw;
    ifg_ctrl_t                    ctrl;

    assign cfg_ready   = 1'b1;
    assign pixel_stall = !emit_free;
    assign accept      = pixel_valid && emit_free;

    // effective frame size
    assign fw_ext = WB'(frame_width_reg);
    always_comb
    begin
        if (fw_ext == '0)
        begin
            w_eff = WB'(1);
        end
        else if (fw_ext > WB'(MAX_WIDTH))
        begin
            w_eff = WB'(MAX_WIDTH);
        end
        else
        begin
            w_eff = fw_ext;
        end
    end
    assign h_eff = (frame_height_reg == '0) ? FH_BITS'(1) : frame_height_reg;

    assign last_col = (WB'(col_reg) + WB'(1)) >= w_eff;
    assign last_row = ((ROW_BITS+1)'(row_reg) + (ROW_BITS+1)'(1))
                      >= (ROW_BITS+1)'(h_eff);

    assign ctrl.has_above = (row_reg != '0);
    assign ctrl.last_col  = last_col;
    assign ctrl.last_row  = last_row;
    assign ctrl.col_nz    = (col_reg != '0);

    assign addr_right = last_col ? col_reg : col_reg + COL_BITS'(1);

    // raster counters
    always_comb
    begin
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_BITS'(1);
        end
        else
        begin
            col_next = col_reg + COL_BITS'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            prev_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            prev_reg <= pixel;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // line store, mirrored so both neighbours of the row above read at once
    ifg_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (pixel),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (above_raw)
    );

    ifg_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_right (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (pixel),
        .rd_en   (accept),
        .rd_addr (addr_right),
        .rd_data (right_raw)
    );

    // result sequencer and output register
    ifg_emit #(
        .PIXEL_BITS (PIXEL_BITS),
        .COL_BITS   (COL_BITS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .load_ctrl  (ctrl),
        .load_pixel (pixel),
        .load_prev  (prev_reg),
        .load_row   (row_reg),
        .load_col   (col_reg),
        .above      (above_raw),
        .right      (right_raw),
        .free       (emit_free),
        .grad_valid (grad_valid),
        .grad_stall (grad_stall),
        .row        (row),
        .col        (col),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .run_last   (run_last)
    );

`ifndef NO_ASSERTIONS
    // a result that is not the last of its pixel is followed at once by the next
    assert property (@(posedge clk) disable iff (!rst_n)
        grad_valid && !grad_stall && !run_last |=> grad_valid)
        else $error("gap inside the results of one pixel");

    // a first-row pixel leaves nothing behind, the next one is taken at once
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (row_reg == '0) && !last_row |=> !pixel_stall)
        else $error("first-row pixel left the sequencer busy");

    // last column of the last row with a left neighbour leaves the input stalled after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_row && last_col && (col_reg != '0) |=> pixel_stall)
        else $error("end of frame results not sequenced");
`endif

endmodule

// ----- src/ifg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifg_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module ifg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/ifg_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifg_emit
// Result sequencer: holds one pixel and issues its up to three results,
// one per cycle into the output register while that register is not stalled.
// ----------------------------------------------------------------------------
module ifg_emit #(
    parameter int PIXEL_BITS = 16,
    parameter int COL_BITS   = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  ifg_pkg::ifg_ctrl_t               load_ctrl,
    input  logic signed [PIXEL_BITS-1:0]     load_pixel,
    input  logic signed [PIXEL_BITS-1:0]     load_prev,
    input  logic [ifg_pkg::ROW_BITS-1:0]     load_row,
    input  logic [COL_BITS-1:0]              load_col,
    input  logic signed [PIXEL_BITS-1:0]     above,
    input  logic signed [PIXEL_BITS-1:0]     right,
    output logic                             free,
    output logic                             grad_valid,
    input  logic                             grad_stall,
    output logic [ifg_pkg::ROW_BITS-1:0]     row,
    output logic [COL_BITS-1:0]              col,
    output logic signed [PIXEL_BITS:0]       grad_x,
    output logic signed [PIXEL_BITS:0]       grad_y,
    output logic                             run_last
);

    import ifg_pkg::*;

    // pending results, bit 0: row above, bit 1: left pixel, bit 2: this pixel
    logic [2:0]                   pend_reg, pend_next, pend_left;
    logic signed [PIXEL_BITS-1:0] pixel_reg, prev_reg;
    logic [ROW_BITS-1:0]          s1_row_reg;
    logic [COL_BITS-1:0]          s1_col_reg;
    logic                         last_col_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [ROW_BITS-1:0]          row_reg, row_next;
    logic [COL_BITS-1:0]          col_reg, col_next;
    logic signed [PIXEL_BITS:0]   gx_reg, gx_next, gy_reg, gy_next;
    logic                         last_reg;

    logic                         slot_free, issue;
    logic signed [PIXEL_BITS:0]   pix_x, prev_x, above_x, right_x;

    assign slot_free = !out_valid_reg || !grad_stall;
    assign issue     = (pend_reg != 3'b000) && slot_free;
    assign pend_left = pend_reg & (pend_reg - 3'b001);
    assign free      = (pend_reg == 3'b000) || (issue && (pend_left == 3'b000));

    assign pix_x   = {pixel_reg[PIXEL_BITS-1], pixel_reg};
    assign prev_x  = {prev_reg[PIXEL_BITS-1], prev_reg};
    assign above_x = {above[PIXEL_BITS-1], above};
    assign right_x = {right[PIXEL_BITS-1], right};

    // pick the oldest pending result
    always_comb
    begin
        row_next = s1_row_reg;
        col_next = s1_col_reg;
        gx_next  = '0;
        gy_next  = '0;
        if (pend_reg[0])
        begin
            row_next = s1_row_reg - ROW_BITS'(1);
            gx_next  = last_col_reg ? '0 : right_x - above_x;
            gy_next  = pix_x - above_x;
        end
        else if (pend_reg[1])
        begin
            col_next = s1_col_reg - COL_BITS'(1);
            gx_next  = pix_x - prev_x;
        end
    end

    // pending mask and output valid
    always_comb
    begin
        if (load)
        begin
            pend_next = {load_ctrl.last_row && load_ctrl.last_col,
                         load_ctrl.last_row && load_ctrl.col_nz,
                         load_ctrl.has_above};
        end
        else if (issue)
        begin
            pend_next = pend_left;
        end
        else
        begin
            pend_next = pend_reg;
        end

        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (grad_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // held pixel
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg    <= load_pixel;
            prev_reg     <= load_prev;
            s1_row_reg   <= load_row;
            s1_col_reg   <= load_col;
            last_col_reg <= load_ctrl.last_col;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            gx_reg   <= gx_next;
            gy_reg   <= gy_next;
            last_reg <= (pend_left == 3'b000);
        end
    end

    assign grad_valid = out_valid_reg;
    assign row        = row_reg;
    assign col        = col_reg;
    assign grad_x     = gx_reg;
    assign grad_y     = gy_reg;
    assign run_last   = last_reg;

endmodule
